### rtl/ctps_pkg.sv
// Package: shared types and constants of the cross-track PID steering block.
`default_nettype none
package ctps_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_P_GAIN    = 3'd0;
    localparam t_cfg_idx CFG_I_GAIN    = 3'd1;
    localparam t_cfg_idx CFG_D_GAIN    = 3'd2;
    localparam t_cfg_idx CFG_TIME_STEP = 3'd3;

    localparam logic [15:0] DT_RESET = 16'd2621;

    // Widths of the geometry terms
    localparam int C2_W = 130;   // squared cross product
    localparam int D_W  = 65;    // squared segment length

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic signed [31:0] p_gain;
        logic signed [31:0] i_gain;
        logic signed [31:0] d_gain;
        logic [15:0]        time_step;
    } t_cfg;

    // Classified item handed from front to back
    typedef struct packed {
        logic [C2_W-1:0] c_sq;
        logic [D_W-1:0]  seg_len_sq;
        logic            cross_pos;
        logic            passed;
        logic            degenerate;
    } t_entry;

endpackage
`default_nettype wire

### rtl/cross_track_pid_steering.sv
// Top level: cross-track PID steering controller with stream ports.
// The back-end sequencer takes one item at a time: a 31-step magnitude search
//   and a 48-step restoring divider, plus six multiply steps.
// The front end and a two-entry queue take the next item meanwhile.
// Reset (i_rst_n low, synchronous): gains 0, time step 2621, accumulator and
//   last error 0, queue and result register empty.
`default_nettype none
module cross_track_pid_steering #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // Config write port
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [31:0]   i_cfg_wdata,
    // Input stream
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // tdata from bit 0: car_x, car_y, from_x, from_y, to_x, to_y (32 each)
    input  wire logic [191:0]  s_axis_tdata,
    // Result stream
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // tdata from bit 0: steer, signed_error (32 each)
    output logic [63:0]        m_axis_tdata,
    // tuser from bit 0: passed, degenerate
    output logic [1:0]         m_axis_tuser
);

    ctps_pkg::t_cfg r_cfg;

    // Hold config registers; ignore writes beyond the register list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.p_gain    <= '0;
            r_cfg.i_gain    <= '0;
            r_cfg.d_gain    <= '0;
            r_cfg.time_step <= ctps_pkg::DT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ctps_pkg::CFG_P_GAIN:    r_cfg.p_gain    <= i_cfg_wdata;
                ctps_pkg::CFG_I_GAIN:    r_cfg.i_gain    <= i_cfg_wdata;
                ctps_pkg::CFG_D_GAIN:    r_cfg.d_gain    <= i_cfg_wdata;
                ctps_pkg::CFG_TIME_STEP: r_cfg.time_step <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    logic             push, full, pop, empty;
    ctps_pkg::t_entry q_in, q_out;
    logic signed [31:0] steer, err;
    logic passed, degen;

    // Front: accept a transaction and build the geometry terms
    ctps_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_car_x  (s_axis_tdata[31:0]),
        .i_car_y  (s_axis_tdata[63:32]),
        .i_from_x (s_axis_tdata[95:64]),
        .i_from_y (s_axis_tdata[127:96]),
        .i_to_x   (s_axis_tdata[159:128]),
        .i_to_y   (s_axis_tdata[191:160]),
        .o_push   (push),
        .i_full   (full),
        .o_entry  (q_in)
    );

    // Decouple front and back so each may stall on its own
    ctps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_empty (empty)
    );

    // Back: error magnitude, PID step, result register
    ctps_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_empty      (empty),
        .o_pop        (pop),
        .i_entry      (q_out),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_steer      (steer),
        .o_error      (err),
        .o_passed     (passed),
        .o_degenerate (degen)
    );

    assign m_axis_tdata = {err, steer};
    assign m_axis_tuser = {degen, passed};

    // A degenerate segment always reports zero steer and zero error
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == 64'd0))
        else $error("degenerate result with nonzero data");

    // Passed is never set together with degenerate
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[1] && m_axis_tuser[0]))
        else $error("passed flagged on degenerate segment");

    // Error magnitude is capped, so the most negative code never appears
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[63:32] != 32'h8000_0000))
        else $error("error magnitude exceeded its cap");

endmodule
`default_nettype wire

### rtl/ctps_front.sv
// Front end: accept an item, form segment products and the squared cross product.
`default_nettype none
module ctps_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic signed [31:0]   i_car_x,
    input  wire logic signed [31:0]   i_car_y,
    input  wire logic signed [31:0]   i_from_x,
    input  wire logic signed [31:0]   i_from_y,
    input  wire logic signed [31:0]   i_to_x,
    input  wire logic signed [31:0]   i_to_y,
    output logic                      o_push,
    input  wire logic                 i_full,
    output ctps_pkg::t_entry          o_entry
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_RUN  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    localparam logic [3:0] LAST_STEP = 4'd9;

    t_fstate r_state, n_state;
    logic [3:0] r_step, n_step;
    logic signed [32:0] r_v1x, r_v1y, r_v2x, r_v2y;
    logic signed [32:0] n_v1x, n_v1y, n_v2x, n_v2y;
    logic signed [67:0] r_prod, n_prod;
    logic signed [66:0] r_d, r_c, r_dot, n_d, n_c, n_dot;
    logic [ctps_pkg::C2_W-1:0] r_c2, n_c2;

    logic [66:0] c_abs;
    logic [31:0] c_hi;
    logic [32:0] c_lo;
    logic signed [33:0] op_a, op_b;

    assign c_abs = r_c[66] ? 67'(-r_c) : 67'(r_c);
    assign c_hi  = c_abs[64:33];
    assign c_lo  = c_abs[32:0];

    // Select the operand pair of this step
    always_comb begin
        unique case (r_step)
            4'd0: begin op_a = {r_v1x[32], r_v1x}; op_b = {r_v1x[32], r_v1x}; end
            4'd1: begin op_a = {r_v1y[32], r_v1y}; op_b = {r_v1y[32], r_v1y}; end
            4'd2: begin op_a = {r_v1x[32], r_v1x}; op_b = {r_v2y[32], r_v2y}; end
            4'd3: begin op_a = {r_v1y[32], r_v1y}; op_b = {r_v2x[32], r_v2x}; end
            4'd4: begin op_a = {r_v1x[32], r_v1x}; op_b = {r_v2x[32], r_v2x}; end
            4'd5: begin op_a = {r_v1y[32], r_v1y}; op_b = {r_v2y[32], r_v2y}; end
            4'd6: begin op_a = {2'b00, c_hi}; op_b = {2'b00, c_hi}; end
            4'd7: begin op_a = {2'b00, c_hi}; op_b = {1'b0, c_lo}; end
            4'd8: begin op_a = {1'b0, c_lo}; op_b = {1'b0, c_lo}; end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_v1x   = r_v1x;
        n_v1y   = r_v1y;
        n_v2x   = r_v2x;
        n_v2y   = r_v2y;
        n_prod  = op_a * op_b;
        n_d     = r_d;
        n_c     = r_c;
        n_dot   = r_dot;
        n_c2    = r_c2;
        unique case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_v1x   = {i_to_x[31], i_to_x} - {i_from_x[31], i_from_x};
                    n_v1y   = {i_to_y[31], i_to_y} - {i_from_y[31], i_from_y};
                    n_v2x   = {i_car_x[31], i_car_x} - {i_from_x[31], i_from_x};
                    n_v2y   = {i_car_y[31], i_car_y} - {i_from_y[31], i_from_y};
                    n_step  = '0;
                    n_state = F_RUN;
                end
            end
            F_RUN: begin
                // Fold in the product of the previous step
                unique case (r_step)
                    4'd1: n_d   = r_prod[66:0];
                    4'd2: n_d   = r_d + r_prod[66:0];
                    4'd3: n_c   = r_prod[66:0];
                    4'd4: n_c   = r_c - r_prod[66:0];
                    4'd5: n_dot = r_prod[66:0];
                    4'd6: n_dot = r_dot + r_prod[66:0];
                    4'd7: n_c2  = {r_prod[63:0], 66'b0};
                    4'd8: n_c2  = r_c2 + {31'b0, r_prod[64:0], 34'b0};
                    4'd9: n_c2  = r_c2 + {64'b0, r_prod[65:0]};
                    default: ;
                endcase
                n_step = r_step + 4'd1;
                if (r_step == LAST_STEP) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
        r_v1x  <= n_v1x;
        r_v1y  <= n_v1y;
        r_v2x  <= n_v2x;
        r_v2y  <= n_v2y;
        r_prod <= n_prod;
        r_d    <= n_d;
        r_c    <= n_c;
        r_dot  <= n_dot;
        r_c2   <= n_c2;
    end

    assign o_ready = (r_state == F_IDLE);
    assign o_push  = (r_state == F_PUSH) && !i_full;

    assign o_entry.c_sq       = r_c2;
    assign o_entry.seg_len_sq = r_d[64:0];
    assign o_entry.cross_pos  = !r_c[66] && (r_c != '0);
    assign o_entry.passed     = (r_dot > r_d);
    assign o_entry.degenerate = (r_d == '0);

endmodule
`default_nettype wire

### rtl/ctps_queue.sv
// Queue: short register FIFO between the front and back ends.
`default_nettype none
module ctps_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire ctps_pkg::t_entry i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output ctps_pkg::t_entry      o_data,
    output logic                  o_empty
);

    localparam int DEPTH = ctps_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ctps_pkg::t_entry r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

### rtl/ctps_back.sv
// Back end: root search, PID update and result register.
`default_nettype none
module ctps_back #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ctps_pkg::t_cfg   i_cfg,
    input  wire logic             i_empty,
    output logic                  o_pop,
    input  wire ctps_pkg::t_entry i_entry,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic signed [31:0]    o_steer,
    output logic signed [31:0]    o_error,
    output logic                  o_passed,
    output logic                  o_degenerate
);

    typedef enum logic [7:0] {
        B_IDLE = 8'b0000_0001,
        B_SRCH = 8'b0000_0010,
        B_MDT  = 8'b0000_0100,
        B_ACC  = 8'b0000_1000,
        B_DIV  = 8'b0001_0000,
        B_MUL  = 8'b0010_0000,
        B_FIN  = 8'b0100_0000,
        B_OUT  = 8'b1000_0000
    } t_bstate;

    localparam int C2_W = ctps_pkg::C2_W;

    t_bstate r_state;
    ctps_pkg::t_entry r_ent;
    logic [C2_W-1:0] r_pa, r_qa, r_bd;
    logic [30:0] r_mag;
    logic [4:0] r_bit;
    logic signed [31:0] r_err, r_last;
    logic signed [47:0] r_acc;
    logic [63:0] r_prod;
    logic [47:0] r_num;
    logic [15:0] r_rem;
    logic r_dneg;
    logic [5:0] r_cnt;
    logic [2:0] r_step;
    logic signed [83:0] r_sum;
    logic r_psign, r_pshift;
    logic signed [31:0] r_rsteer;
    logic r_out_valid;
    logic signed [31:0] r_steer, r_oerr;
    logic r_opassed, r_odegen;

    logic [15:0] dt;
    assign dt = (i_cfg.time_step == '0) ? 16'd1 : i_cfg.time_step;

    // Root search step: try setting the current magnitude bit
    logic [C2_W-1:0] cand;
    logic take;
    assign cand = r_pa + r_qa + r_bd;
    assign take = (cand <= r_ent.c_sq);

    // Accumulator update
    logic [30:0] inc_mag;
    logic signed [48:0] inc, acc_sum;
    logic signed [47:0] acc_sat;
    logic signed [32:0] diff;
    logic [32:0] diff_mag;
    assign inc_mag  = r_prod[46:16];
    assign inc      = r_err[31] ? -$signed({18'b0, inc_mag}) : $signed({18'b0, inc_mag});
    assign acc_sum  = {r_acc[47], r_acc} + inc;
    assign acc_sat  = (acc_sum > 49'sh0_7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF :
                      (acc_sum < -49'sh0_8000_0000_0000) ? -48'sh8000_0000_0000 :
                      acc_sum[47:0];
    assign diff     = {r_err[31], r_err} - {r_last[31], r_last};
    assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);

    // Divider step
    logic [16:0] div_sh;
    logic div_ge;
    assign div_sh = {r_rem, r_num[47]};
    assign div_ge = (div_sh >= {1'b0, dt});

    // Partial product operands
    logic [31:0] p_mag, i_mag, d_mag;
    logic [47:0] acc_mag;
    logic [31:0] mul_a, mul_b;
    logic mul_sign, mul_shift;
    assign p_mag   = i_cfg.p_gain[31] ? 32'(-i_cfg.p_gain) : 32'(i_cfg.p_gain);
    assign i_mag   = i_cfg.i_gain[31] ? 32'(-i_cfg.i_gain) : 32'(i_cfg.i_gain);
    assign d_mag   = i_cfg.d_gain[31] ? 32'(-i_cfg.d_gain) : 32'(i_cfg.d_gain);
    assign acc_mag = r_acc[47] ? 48'(-r_acc) : 48'(r_acc);

    always_comb begin
        mul_a = '0; mul_b = '0; mul_sign = 1'b0; mul_shift = 1'b0;
        if (r_state == B_MDT) begin
            mul_a = {1'b0, r_mag};
            mul_b = {16'b0, dt};
        end else begin
            unique case (r_step)
                3'd0: begin mul_a = p_mag; mul_b = {1'b0, r_mag};
                    mul_sign = i_cfg.p_gain[31] ^ r_err[31]; end
                3'd1: begin mul_a = i_mag; mul_b = acc_mag[31:0];
                    mul_sign = i_cfg.i_gain[31] ^ r_acc[47]; end
                3'd2: begin mul_a = i_mag; mul_b = {16'b0, acc_mag[47:32]};
                    mul_sign = i_cfg.i_gain[31] ^ r_acc[47]; mul_shift = 1'b1; end
                3'd3: begin mul_a = d_mag; mul_b = r_num[31:0];
                    mul_sign = i_cfg.d_gain[31] ^ r_dneg; end
                3'd4: begin mul_a = d_mag; mul_b = {16'b0, r_num[47:32]};
                    mul_sign = i_cfg.d_gain[31] ^ r_dneg; mul_shift = 1'b1; end
                default: ;
            endcase
        end
    end

    logic signed [83:0] term;
    assign term = r_pshift ? $signed({r_prod[51:0], 32'b0}) : $signed({20'b0, r_prod});

    // Final scale and clamp
    logic [83:0] sum_mag, sum_sh;
    logic sum_big;
    logic signed [31:0] steer_sat;
    assign sum_mag   = r_sum[83] ? 84'(-r_sum) : 84'(r_sum);
    assign sum_sh    = sum_mag >> FRAC_BITS;
    assign sum_big   = (sum_sh[83:31] != '0);
    assign steer_sat = r_sum[83] ? (sum_big ? 32'sh8000_0000 : -$signed(sum_sh[31:0])) :
                       (sum_big ? 32'sh7FFF_FFFF : $signed(sum_sh[31:0]));

    assign o_pop = (r_state == B_IDLE) && !i_empty;

    // Load the result register when it is empty or being drained
    logic out_load;
    assign out_load = (r_state == B_OUT) && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_acc       <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
            r_bit       <= '0;
            r_cnt       <= '0;
            r_step      <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_ent <= i_entry;
                        r_pa  <= '0;
                        r_qa  <= '0;
                        r_bd  <= {5'b0, i_entry.seg_len_sq, 60'b0};
                        r_mag <= '0;
                        r_bit <= 5'd30;
                        if (i_entry.degenerate) begin
                            r_err    <= '0;
                            r_rsteer <= '0;
                            r_state  <= B_OUT;
                        end else begin
                            r_state <= B_SRCH;
                        end
                    end
                end
                B_SRCH: begin
                    if (take) begin
                        r_pa         <= cand;
                        r_mag[r_bit] <= 1'b1;
                    end
                    r_qa  <= (r_qa >> 1) + (take ? r_bd : '0);
                    r_bd  <= r_bd >> 2;
                    r_bit <= r_bit - 5'd1;
                    if (r_bit == '0) begin
                        r_state <= B_MDT;
                    end
                end
                B_MDT: begin
                    r_err   <= r_ent.cross_pos ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
                    r_state <= B_ACC;
                end
                B_ACC: begin
                    r_acc   <= acc_sat;
                    r_last  <= r_err;
                    r_num   <= {diff_mag[31:0], 16'b0};
                    r_dneg  <= diff[32];
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_sum   <= '0;
                    r_step  <= '0;
                    r_state <= B_DIV;
                end
                B_DIV: begin
                    r_rem   <= div_ge ? 16'(div_sh - {1'b0, dt}) : div_sh[15:0];
                    r_num   <= {r_num[46:0], div_ge};
                    r_cnt   <= r_cnt + 6'd1;
                    if (r_cnt == 6'd47) begin
                        r_state <= B_MUL;
                    end
                end
                B_MUL: begin
                    if (r_step != '0) begin
                        r_sum <= r_psign ? r_sum - term : r_sum + term;
                    end
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd5) begin
                        r_state <= B_FIN;
                    end
                end
                B_FIN: begin
                    r_rsteer <= steer_sat;
                    r_state  <= B_OUT;
                end
                B_OUT: begin
                    if (out_load) begin
                        r_steer     <= r_rsteer;
                        r_oerr      <= r_err;
                        r_opassed   <= r_ent.passed && !r_ent.degenerate;
                        r_odegen    <= r_ent.degenerate;
                        r_state     <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
        r_prod   <= mul_a * mul_b;
        r_psign  <= mul_sign;
        r_pshift <= mul_shift;
    end

    assign o_valid      = r_out_valid;
    assign o_steer      = r_steer;
    assign o_error      = r_oerr;
    assign o_passed     = r_opassed;
    assign o_degenerate = r_odegen;

endmodule
`default_nettype wire
